// File: hw/rtl/tzk_pkg.sv
// Shared types, constants and helpers of the touch zone key mapper.
`timescale 1ns / 1ps
package tzk_pkg;

    localparam int MAX_CONTACTS_DEF = 16;
    localparam int MAX_ZONES_DEF    = 32;
    localparam int RESULT_LIMIT     = 32;

    localparam int RAW_W  = 24;
    localparam int ORG_W  = 16;
    localparam int SIZE_W = 15;
    localparam int ZB_W   = 16;
    localparam int KEY_W  = 16;
    localparam int ID_W   = 16;
    localparam int ZIDX_W = 5;
    localparam int ZCNT_W = 6;
    localparam int DIV_W  = 28;   // dividend and quotient width
    localparam int DIFF_W = 19;
    localparam int PROD_W = 29;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // raw / 100 as (|raw| * ceil(2^REC_SH / 100)) >> REC_SH, exact for |raw| < 2^24
    localparam int RAW_DIV = 100;
    localparam int REC_W   = 25;
    localparam int REC_SH  = 31;
    localparam logic [REC_W-1:0] RECIP_100 =
        REC_W'(((64'd1 << REC_SH) + 64'(RAW_DIV - 1)) / 64'(RAW_DIV));

    localparam logic signed [PROD_W-1:0] REL_SCALE = PROD_W'(1000);

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_DOWN = 2'd1;
    localparam logic [1:0] FUNC_MOVE = 2'd2;
    localparam logic [1:0] FUNC_UP   = 2'd3;

    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_AREA_WIDTH  = 3'd2;
    localparam logic [2:0] REG_AREA_HEIGHT = 3'd3;
    localparam logic [2:0] REG_ZONE_COUNT  = 3'd4;

    typedef struct packed {
        logic signed [ZB_W-1:0] left;
        logic signed [ZB_W-1:0] top;
        logic signed [ZB_W-1:0] right;
        logic signed [ZB_W-1:0] bottom;
    } t_bounds;

    // query that walks the zone cells
    typedef struct packed {
        logic                    valid;
        logic                    old_en;
        logic                    new_en;
        logic signed [DIV_W-1:0] ox;
        logic signed [DIV_W-1:0] oy;
        logic signed [DIV_W-1:0] nx;
        logic signed [DIV_W-1:0] ny;
    } t_query;

    function automatic logic in_box(input logic signed [DIV_W-1:0] x,
                                    input logic signed [DIV_W-1:0] y,
                                    input t_bounds b);
        logic signed [DIV_W-1:0] l, t, r, bo;
        l  = DIV_W'(b.left);
        t  = DIV_W'(b.top);
        r  = DIV_W'(b.right);
        bo = DIV_W'(b.bottom);
        return (x > l) && (x < r) && (y > t) && (y < bo);
    endfunction

endpackage

// File: hw/rtl/tzk_in_if.sv
// Request channel carrying touch and zone load items.
`timescale 1ns / 1ps
interface tzk_in_if import tzk_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             func;
    logic [ID_W-1:0]        contact_id;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic [ZIDX_W-1:0]      zone_index;
    logic signed [ZB_W-1:0] zone_left;
    logic signed [ZB_W-1:0] zone_top;
    logic signed [ZB_W-1:0] zone_right;
    logic signed [ZB_W-1:0] zone_bottom;
    logic [KEY_W-1:0]       zone_key;

    modport source (output valid, func, contact_id, raw_x, raw_y, zone_index,
                    zone_left, zone_top, zone_right, zone_bottom, zone_key,
                    input ready);
    modport sink (input valid, func, contact_id, raw_x, raw_y, zone_index,
                  zone_left, zone_top, zone_right, zone_bottom, zone_key,
                  output ready);
endinterface

// File: hw/rtl/tzk_out_if.sv
// Key event channel.
`timescale 1ns / 1ps
interface tzk_out_if import tzk_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_code;
    logic             key_release;
    logic             last;
    logic             overflow;

    modport source (output valid, key_code, key_release, last, overflow,
                    input ready);
    modport sink (input valid, key_code, key_release, last, overflow,
                  output ready);
endinterface

// File: hw/rtl/tzk_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tzk_div import tzk_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DIV_W-1:0] i_dividend,
    input  logic [SIZE_W-1:0]       i_divisor,
    output logic                    o_done,
    output logic signed [DIV_W-1:0] o_quot
);
    localparam int CW = $clog2(DIV_W);

    logic              r_busy, r_done, r_neg;
    logic [CW-1:0]     r_cnt;
    logic [SIZE_W-1:0] r_rem, r_div;
    logic [DIV_W-1:0]  r_quo;
    logic [SIZE_W:0]   rem_sh;
    logic              ge;

    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DIV_W-1];
            r_quo <= i_dividend[DIV_W-1] ? -i_dividend : i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? SIZE_W'(rem_sh - {1'b0, r_div}) : rem_sh[SIZE_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule

// File: hw/rtl/tzk_zone_cell.sv
// One zone of the chain: holds its bounds and key, tests the passing query.
`timescale 1ns / 1ps
module tzk_zone_cell import tzk_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_wr,
    input  t_bounds          i_wr_bounds,
    input  logic [KEY_W-1:0] i_wr_key,
    input  logic             i_active,
    input  t_query           i_q,
    output t_query           o_q,
    output logic             o_hit,
    output logic [KEY_W-1:0] o_key,
    output logic             o_release
);
    t_bounds          r_bounds;
    logic [KEY_W-1:0] r_key;
    t_query           r_q;
    logic             was, now;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_bounds <= i_wr_bounds;
            r_key    <= i_wr_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_adv) begin
            r_q <= i_q;
        end
    end

    assign was = r_q.old_en && in_box(r_q.ox, r_q.oy, r_bounds);
    assign now = r_q.new_en && in_box(r_q.nx, r_q.ny, r_bounds);

    assign o_q       = r_q;
    assign o_hit     = r_q.valid && i_active && (was != now);
    assign o_key     = r_key;
    assign o_release = was;
endmodule

// File: hw/rtl/touch_zone_key_mapper.sv
// Top level of the touch zone key mapper.
`timescale 1ns / 1ps
// Maps touch contacts onto rectangular zones and sends key press/release
// events. Items are taken one at a time. A zone load is written as it is
// accepted. A down or move divides by 100 with a reciprocal multiply in
// S_RECIP, scales in S_MUL, then runs a pair of bit-serial dividers by the
// area size (started in S_D2S, awaited in S_D2), then the S_FIND lookup
// sends the query down the chain of MAX_ZONES zone cells at one cell per
// cycle; an up skips the arithmetic and goes straight to the lookup.
// The walk pauses while the output register is full. Events leave in
// ascending zone order, the last of an item marked with last.
module touch_zone_key_mapper import tzk_pkg::*; #(
    parameter int MAX_CONTACTS = MAX_CONTACTS_DEF,
    parameter int MAX_ZONES    = MAX_ZONES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    tzk_in_if.sink             i_in,
    tzk_out_if.source          o_out
);
    localparam int SW    = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CNT_W = $clog2(RESULT_LIMIT + 1);
    localparam int REC_P = RAW_W + REC_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RECIP = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_D2S   = 4'd3;
    localparam logic [3:0] S_D2    = 4'd4;
    localparam logic [3:0] S_FIND  = 4'd5;
    localparam logic [3:0] S_WAVE  = 4'd6;
    localparam logic [3:0] S_FLUSH = 4'd7;

    // configuration
    logic signed [ORG_W-1:0] r_origin_x, r_origin_y;
    logic [SIZE_W-1:0]       r_area_w, r_area_h;
    logic [ZCNT_W-1:0]       r_zone_count;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_area_w     <= SIZE_W'(1000);
            r_area_h     <= SIZE_W'(1000);
            r_zone_count <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_ORIGIN_X:    r_origin_x   <= pwdata[ORG_W-1:0];
                REG_ORIGIN_Y:    r_origin_y   <= pwdata[ORG_W-1:0];
                REG_AREA_WIDTH:  r_area_w     <= pwdata[SIZE_W-1:0];
                REG_AREA_HEIGHT: r_area_h     <= pwdata[SIZE_W-1:0];
                REG_ZONE_COUNT:  r_zone_count <= pwdata[ZCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_ORIGIN_X:    prdata = DATA_W'(unsigned'(r_origin_x));
            REG_ORIGIN_Y:    prdata = DATA_W'(unsigned'(r_origin_y));
            REG_AREA_WIDTH:  prdata = DATA_W'(r_area_w);
            REG_AREA_HEIGHT: prdata = DATA_W'(r_area_h);
            REG_ZONE_COUNT:  prdata = DATA_W'(r_zone_count);
            default:         prdata = '0;
        endcase
    end

    // request latch and control
    logic [3:0]              r_state;
    logic [1:0]              r_func;
    logic [ID_W-1:0]         r_id;
    logic signed [RAW_W-1:0] r_raw_x, r_raw_y;
    logic                    acc;

    assign i_in.ready = (r_state == S_IDLE);
    assign acc        = i_in.valid && (r_state == S_IDLE);

    // divide by 100, truncating toward zero
    logic [RAW_W-1:0]         abs_x, abs_y;
    logic [REC_P-1:0]         rec_x, rec_y;
    logic signed [DIFF_W-1:0] q100_x, q100_y, r_q100_x, r_q100_y;

    assign abs_x  = r_raw_x[RAW_W-1] ? unsigned'(-r_raw_x) : unsigned'(r_raw_x);
    assign abs_y  = r_raw_y[RAW_W-1] ? unsigned'(-r_raw_y) : unsigned'(r_raw_y);
    assign rec_x  = REC_P'(abs_x) * REC_P'(RECIP_100);
    assign rec_y  = REC_P'(abs_y) * REC_P'(RECIP_100);
    assign q100_x = r_raw_x[RAW_W-1] ? -$signed({1'b0, rec_x[REC_SH +: DIFF_W-1]})
                                     :  $signed({1'b0, rec_x[REC_SH +: DIFF_W-1]});
    assign q100_y = r_raw_y[RAW_W-1] ? -$signed({1'b0, rec_y[REC_SH +: DIFF_W-1]})
                                     :  $signed({1'b0, rec_y[REC_SH +: DIFF_W-1]});

    // dividers by the area size
    logic                    div_start, dx_done, dy_done;
    logic signed [DIV_W-1:0] dx_q, dy_q;
    logic [SIZE_W-1:0]       dx_dvs, dy_dvs;
    logic signed [DIV_W-1:0] r_prod_x, r_prod_y, r_x, r_y;
    logic signed [DIFF_W-1:0] diff_x, diff_y;
    logic signed [PROD_W-1:0] prod_x, prod_y;

    assign div_start = (r_state == S_D2S);
    assign dx_dvs    = (r_area_w == '0) ? SIZE_W'(1) : r_area_w;
    assign dy_dvs    = (r_area_h == '0) ? SIZE_W'(1) : r_area_h;

    tzk_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(r_prod_x), .i_divisor(dx_dvs), .o_done(dx_done), .o_quot(dx_q)
    );

    tzk_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(r_prod_y), .i_divisor(dy_dvs), .o_done(dy_done), .o_quot(dy_q)
    );

    assign diff_x = r_q100_x - DIFF_W'(r_origin_x);
    assign diff_y = r_q100_y - DIFF_W'(r_origin_y);
    assign prod_x = PROD_W'(diff_x) * REL_SCALE;
    assign prod_y = PROD_W'(diff_y) * REL_SCALE;

    // contact table
    logic                    r_cvalid [MAX_CONTACTS];
    logic [ID_W-1:0]         r_cid    [MAX_CONTACTS];
    logic signed [DIV_W-1:0] r_cx     [MAX_CONTACTS];
    logic signed [DIV_W-1:0] r_cy     [MAX_CONTACTS];
    logic                    found, free_any;
    logic [SW-1:0]           found_slot, free_slot;

    always_comb begin
        found      = 1'b0;
        free_any   = 1'b0;
        found_slot = '0;
        free_slot  = '0;
        // walk downward so the lowest slot wins
        for (int i = MAX_CONTACTS - 1; i >= 0; i--) begin
            if (r_cvalid[i] && r_cid[i] == r_id) begin
                found      = 1'b1;
                found_slot = SW'(i);
            end
            if (!r_cvalid[i]) begin
                free_any  = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    // zone chain
    t_query           w_q   [MAX_ZONES+1];
    logic             w_hit [MAX_ZONES];
    logic [KEY_W-1:0] w_key [MAX_ZONES];
    logic             w_rel [MAX_ZONES];
    t_query           r_inj;
    t_bounds          wr_bounds;
    logic             adv;

    assign w_q[0]    = r_inj;
    assign wr_bounds = '{left: i_in.zone_left, top: i_in.zone_top,
                         right: i_in.zone_right, bottom: i_in.zone_bottom};

    for (genvar g = 0; g < MAX_ZONES; g++) begin : g_zone
        tzk_zone_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_wr       (acc && i_in.func == FUNC_LOAD &&
                         7'(i_in.zone_index) == 7'(g)),
            .i_wr_bounds(wr_bounds),
            .i_wr_key   (i_in.zone_key),
            .i_active   (7'(r_zone_count) > 7'(g)),
            .i_q        (w_q[g]),
            .o_q        (w_q[g+1]),
            .o_hit      (w_hit[g]),
            .o_key      (w_key[g]),
            .o_release  (w_rel[g])
        );
    end

    // only one cell holds the query, so an AND-OR select suffices
    logic             hit_any, hit_rel, hit_eff;
    logic [KEY_W-1:0] hit_key;

    always_comb begin
        hit_any = 1'b0;
        hit_rel = 1'b0;
        hit_key = '0;
        for (int i = 0; i < MAX_ZONES; i++) begin
            if (w_hit[i]) begin
                hit_any = 1'b1;
                hit_rel = hit_rel | w_rel[i];
                hit_key = hit_key | w_key[i];
            end
        end
    end

    // event staging: hold one event until it is known whether it is last
    logic             r_pend_v, r_pend_rel;
    logic [KEY_W-1:0] r_pend_key;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic             r_out_v, r_out_rel, r_out_last, r_out_ovf;
    logic [KEY_W-1:0] r_out_key;
    logic             out_free, push, push_last, wave_end;

    assign hit_eff  = hit_any && (r_cnt != CNT_W'(RESULT_LIMIT));
    assign out_free = !r_out_v || o_out.ready;
    assign adv      = (r_state == S_WAVE) && !(hit_eff && r_pend_v && !out_free);
    assign wave_end = adv && w_q[MAX_ZONES].valid;
    assign push_last = (r_state == S_FLUSH) && r_pend_v && out_free;
    assign push     = (adv && hit_eff && r_pend_v) || push_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (push) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_key  <= r_pend_key;
            r_out_rel  <= r_pend_rel;
            r_out_last <= push_last;
            r_out_ovf  <= r_ovf;
        end
        if (adv && hit_eff) begin
            r_pend_key <= hit_key;
            r_pend_rel <= hit_rel;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.key_code    = r_out_key;
    assign o_out.key_release = r_out_rel;
    assign o_out.last        = r_out_last;
    assign o_out.overflow    = r_out_ovf;

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovf     <= 1'b0;
            r_pend_v  <= 1'b0;
            r_cnt     <= '0;
            r_inj.valid <= 1'b0;
            for (int i = 0; i < MAX_CONTACTS; i++) r_cvalid[i] <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        priority case (i_in.func)
                            FUNC_LOAD: r_state <= S_IDLE;
                            FUNC_UP:   r_state <= S_FIND;
                            default:   r_state <= S_RECIP;
                        endcase
                    end
                end
                S_RECIP: r_state <= S_MUL;
                S_MUL: r_state <= S_D2S;
                S_D2S: r_state <= S_D2;
                S_D2: begin
                    if (dx_done && dy_done) r_state <= S_FIND;
                end
                S_FIND: begin
                    r_cnt    <= '0;
                    r_inj.nx <= r_x;
                    r_inj.ny <= r_y;
                    r_inj.ox <= r_cx[found_slot];
                    r_inj.oy <= r_cy[found_slot];
                    if (r_func == FUNC_UP) begin
                        r_inj.old_en <= 1'b1;
                        r_inj.new_en <= 1'b0;
                    end else begin
                        r_inj.old_en <= found && (r_func == FUNC_MOVE);
                        r_inj.new_en <= 1'b1;
                    end
                    if (r_func == FUNC_UP) begin
                        if (found) begin
                            r_cvalid[found_slot] <= 1'b0;
                            r_inj.valid <= 1'b1;
                            r_state     <= S_WAVE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (found) begin
                        r_inj.valid <= 1'b1;
                        r_state     <= S_WAVE;
                    end else if (free_any) begin
                        r_cvalid[free_slot] <= 1'b1;
                        if (r_func == FUNC_DOWN) begin
                            r_inj.valid <= 1'b1;
                            r_state     <= S_WAVE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_ovf   <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_WAVE: begin
                    if (adv) begin
                        r_inj.valid <= 1'b0;
                        if (hit_eff) begin
                            r_pend_v <= 1'b1;
                            r_cnt    <= r_cnt + CNT_W'(1);
                        end
                    end
                    if (wave_end) r_state <= S_FLUSH;
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_func  <= i_in.func;
            r_id    <= i_in.contact_id;
            r_raw_x <= i_in.raw_x;
            r_raw_y <= i_in.raw_y;
        end
        if (r_state == S_RECIP) begin
            r_q100_x <= q100_x;
            r_q100_y <= q100_y;
        end
        if (r_state == S_MUL) begin
            r_prod_x <= prod_x[DIV_W-1:0];
            r_prod_y <= prod_y[DIV_W-1:0];
        end
        if (r_state == S_D2 && dx_done && dy_done) begin
            r_x <= dx_q;
            r_y <= dy_q;
        end
        if (r_state == S_FIND) begin
            if (r_func != FUNC_UP) begin
                if (found) begin
                    r_cx[found_slot] <= r_x;
                    r_cy[found_slot] <= r_y;
                end else if (free_any) begin
                    r_cid[free_slot] <= r_id;
                    r_cx[free_slot]  <= r_x;
                    r_cy[free_slot]  <= r_y;
                end
            end
        end
    end
endmodule

// File: verif/tb_touch_zone_key_mapper.sv
// Testbench for the touch zone key mapper: random and directed touch traffic.
`timescale 1ns / 1ps
module tb_touch_zone_key_mapper;
    import tzk_pkg::*;

    typedef struct {
        logic [1:0]              func;
        logic [ID_W-1:0]         id;
        logic signed [RAW_W-1:0] rx;
        logic signed [RAW_W-1:0] ry;
        logic [ZIDX_W-1:0]       zidx;
        logic signed [ZB_W-1:0]  zl, zt, zr, zb;
        logic [KEY_W-1:0]        key;
    } t_touch_req;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic             rel;
        logic             last;
        logic             ovf;
    } t_key_event;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    tzk_in_if  in_ch ();
    tzk_out_if out_ch ();

    touch_zone_key_mapper i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in(in_ch), .o_out(out_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    int  org_x = 0, org_y = 0, size_w = 1000, size_h = 1000, zones_used = 0;
    bit  slot_busy [MAX_CONTACTS_DEF];
    logic [ID_W-1:0] slot_id [MAX_CONTACTS_DEF];
    int  slot_x [MAX_CONTACTS_DEF];
    int  slot_y [MAX_CONTACTS_DEF];
    int  zn_l [MAX_ZONES_DEF], zn_t [MAX_ZONES_DEF];
    int  zn_r [MAX_ZONES_DEF], zn_b [MAX_ZONES_DEF];
    logic [KEY_W-1:0] zn_key [MAX_ZONES_DEF];
    bit  ovf_seen = 0;

    t_touch_req pending_reqs[$];
    t_key_event expected_keys[$];
    t_touch_req cur;
    int  errors = 0;
    bit  quiet = 0;
    int  send_gap = 0, sink_gap = 0;

    function automatic int scale_coord(logic signed [RAW_W-1:0] raw, int org, int sz);
        int r, d;
        r = int'(raw) / 100;
        d = (sz == 0) ? 1 : sz;
        return (r - org) * 1000 / d;
    endfunction

    function automatic bit zone_hit(int z, int x, int y);
        return x > zn_l[z] && x < zn_r[z] && y > zn_t[z] && y < zn_b[z];
    endfunction

    function automatic int find_slot(logic [ID_W-1:0] id);
        for (int i = 0; i < MAX_CONTACTS_DEF; i++)
            if (slot_busy[i] && slot_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void predict_keys(t_touch_req q);
        t_key_event ev[$];
        t_key_event e;
        int nz, s, x, y;
        bit was, now;
        nz = (zones_used < MAX_ZONES_DEF) ? zones_used : MAX_ZONES_DEF;
        if (q.func == FUNC_LOAD) begin
            zn_l[q.zidx] = int'(q.zl);
            zn_t[q.zidx] = int'(q.zt);
            zn_r[q.zidx] = int'(q.zr);
            zn_b[q.zidx] = int'(q.zb);
            zn_key[q.zidx] = q.key;
            return;
        end
        s = find_slot(q.id);
        if (q.func == FUNC_UP) begin
            if (s < 0) return;
            for (int z = 0; z < nz; z++)
                if (zone_hit(z, slot_x[s], slot_y[s])) begin
                    e = '{zn_key[z], 1'b1, 1'b0, 1'b0};
                    ev.push_back(e);
                end
            slot_busy[s] = 0;
        end else begin
            x = scale_coord(q.rx, org_x, size_w);
            y = scale_coord(q.ry, org_y, size_h);
            if (s < 0) begin
                for (int i = 0; i < MAX_CONTACTS_DEF; i++)
                    if (!slot_busy[i]) begin
                        s = i;
                        break;
                    end
                if (s < 0) begin
                    ovf_seen = 1;
                    return;
                end
                slot_busy[s] = 1;
                slot_id[s] = q.id;
                if (q.func == FUNC_DOWN)
                    for (int z = 0; z < nz; z++)
                        if (zone_hit(z, x, y)) begin
                            e = '{zn_key[z], 1'b0, 1'b0, 1'b0};
                            ev.push_back(e);
                        end
            end else if (q.func == FUNC_DOWN) begin
                for (int z = 0; z < nz; z++)
                    if (zone_hit(z, x, y)) begin
                        e = '{zn_key[z], 1'b0, 1'b0, 1'b0};
                        ev.push_back(e);
                    end
            end else begin
                for (int z = 0; z < nz; z++) begin
                    was = zone_hit(z, slot_x[s], slot_y[s]);
                    now = zone_hit(z, x, y);
                    if (was != now) begin
                        e = '{zn_key[z], was, 1'b0, 1'b0};
                        ev.push_back(e);
                    end
                end
            end
            slot_x[s] = x;
            slot_y[s] = y;
        end
        foreach (ev[k]) begin
            ev[k].ovf = ovf_seen;
            ev[k].last = (k == ev.size() - 1);
            if (k < RESULT_LIMIT) expected_keys.push_back(ev[k]);
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.func <= FUNC_LOAD;
            in_ch.contact_id <= '0;
            in_ch.raw_x <= '0;
            in_ch.raw_y <= '0;
            in_ch.zone_index <= '0;
            in_ch.zone_left <= '0;
            in_ch.zone_top <= '0;
            in_ch.zone_right <= '0;
            in_ch.zone_bottom <= '0;
            in_ch.zone_key <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_keys(cur);
            if (in_ch.valid && !in_ch.ready) begin
                // hold the request
            end else if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                cur = pending_reqs.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.func <= cur.func;
                in_ch.contact_id <= cur.id;
                in_ch.raw_x <= cur.rx;
                in_ch.raw_y <= cur.ry;
                in_ch.zone_index <= cur.zidx;
                in_ch.zone_left <= cur.zl;
                in_ch.zone_top <= cur.zt;
                in_ch.zone_right <= cur.zr;
                in_ch.zone_bottom <= cur.zb;
                in_ch.zone_key <= cur.key;
                if (!quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 6);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // key event monitor and sink stalls
    always @(posedge i_clk) begin
        t_key_event e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_keys.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected key event key=%h rel=%b", out_ch.key_code,
                                 out_ch.key_release);
                end else begin
                    e = expected_keys.pop_front();
                    if (out_ch.key_code !== e.key || out_ch.key_release !== e.rel ||
                        out_ch.last !== e.last || out_ch.overflow !== e.ovf) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp key=%h rel=%b last=%b ovf=%b, got %h %b %b %b",
                                     e.key, e.rel, e.last, e.ovf, out_ch.key_code,
                                     out_ch.key_release, out_ch.last, out_ch.overflow);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 6);
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ORIGIN_X:    org_x = int'($signed(val[15:0]));
            REG_ORIGIN_Y:    org_y = int'($signed(val[15:0]));
            REG_AREA_WIDTH:  size_w = int'(val[14:0]);
            REG_AREA_HEIGHT: size_h = int'(val[14:0]);
            REG_ZONE_COUNT:  zones_used = int'(val[5:0]);
            default: ;
        endcase
    endtask

    // drain everything, then allow a no-result item to finish inside the block
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || in_ch.valid || expected_keys.size() != 0);
        repeat (200) @(negedge i_clk);
    endtask

    function automatic void add_touch(logic [1:0] f, logic [ID_W-1:0] id, int rx, int ry);
        t_touch_req q;
        q.func = f;
        q.id = id;
        q.rx = RAW_W'(rx);
        q.ry = RAW_W'(ry);
        q.zidx = ZIDX_W'($urandom);
        q.zl = ZB_W'($urandom);
        q.zt = ZB_W'($urandom);
        q.zr = ZB_W'($urandom);
        q.zb = ZB_W'($urandom);
        q.key = KEY_W'($urandom);
        pending_reqs.push_back(q);
    endfunction

    function automatic void add_zone(int idx, int l, int t, int r, int b, int key);
        t_touch_req q;
        q.func = FUNC_LOAD;
        q.id = ID_W'($urandom);
        q.rx = RAW_W'($urandom);
        q.ry = RAW_W'($urandom);
        q.zidx = ZIDX_W'(idx);
        q.zl = ZB_W'(l);
        q.zt = ZB_W'(t);
        q.zr = ZB_W'(r);
        q.zb = ZB_W'(b);
        q.key = KEY_W'(key);
        pending_reqs.push_back(q);
    endfunction

    function automatic void add_random_zone(int idx);
        int l, t;
        if ($urandom_range(0, 7) == 0) begin
            add_zone(idx, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            l = $urandom_range(0, 800) - 100;
            t = $urandom_range(0, 800) - 100;
            add_zone(idx, l, t, l + $urandom_range(50, 500), t + $urandom_range(50, 500),
                     $urandom);
        end
    endfunction

    // raw position that mostly lands inside the touch area
    function automatic int pick_raw(int org, int sz);
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 16777215)) - 8388608;
        return (org + $urandom_range(0, (sz == 0) ? 1 : sz)) * 100 + $urandom_range(0, 99);
    endfunction

    function automatic void add_random_req();
        int sel;
        logic [ID_W-1:0] id;
        sel = $urandom_range(0, 99);
        id = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 19));
        if (sel < 5)
            add_random_zone($urandom_range(0, MAX_ZONES_DEF - 1));
        else if (sel < 35)
            add_touch(FUNC_DOWN, id, pick_raw(org_x, size_w), pick_raw(org_y, size_h));
        else if (sel < 75)
            add_touch(FUNC_MOVE, id, pick_raw(org_x, size_w), pick_raw(org_y, size_h));
        else
            add_touch(FUNC_UP, id, $urandom, $urandom);
    endfunction

    initial begin
        int settings [6][5] = '{
            '{0, 0, 1000, 1000, 32},
            '{-32768, 32767, 32767, 1, 63},
            '{100, -50, 640, 480, 8},
            '{32767, -32768, 0, 0, 0},
            '{0, 0, 1, 32767, 32},
            '{20, 10, 800, 600, 32}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole zone table before any zone can be walked
        add_zone(0, -32768, -32768, 32767, 32767, 16'hFFFF);
        add_zone(1, 100, 100, 300, 300, 16'h0000);
        add_zone(31, 32767, 32767, -32768, -32768, 16'hA5A5);
        for (int z = 2; z < 31; z++) add_random_zone(z);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            reg_write(REG_ORIGIN_X, settings[p][0]);
            reg_write(REG_ORIGIN_Y, settings[p][1]);
            reg_write(REG_AREA_WIDTH, settings[p][2]);
            reg_write(REG_AREA_HEIGHT, settings[p][3]);
            reg_write(REG_ZONE_COUNT, settings[p][4]);
            if (p == 0) begin
                add_touch(FUNC_DOWN, 1, 20000, 20000);
                add_touch(FUNC_MOVE, 1, 50000, 50000);
                add_touch(FUNC_MOVE, 1, 10000, 20000);    // on a zone edge: not inside
                add_touch(FUNC_MOVE, 1, 25000, 25000);
                add_touch(FUNC_DOWN, 1, 15000, 15000);    // known contact pressed again
                add_touch(FUNC_MOVE, 7, 20000, 20000);    // unknown contact gets stored
                add_touch(FUNC_UP, 1, 0, 0);
                add_touch(FUNC_UP, 1, 0, 0);              // no longer known
                add_touch(FUNC_UP, 7, 0, 0);
                add_touch(FUNC_DOWN, 2, 8388607, -8388608);
                add_touch(FUNC_MOVE, 2, -8388608, 8388607);
                add_touch(FUNC_UP, 2, 0, 0);
                add_touch(FUNC_DOWN, 3, -99, -150);       // truncation toward zero
                add_touch(FUNC_UP, 3, 0, 0);
                add_touch(FUNC_DOWN, 16'hFFFF, 12345, 67890);
                add_touch(FUNC_DOWN, 16'h0000, 30000, 90000);
                add_touch(FUNC_UP, 16'hFFFF, 0, 0);
                add_touch(FUNC_UP, 16'h0000, 0, 0);
            end
            if (p == 5) begin
                wait_drained();
                quiet = 1;
            end
            for (int n = 0; n < 35; n++) add_random_req();
            wait_drained();
        end

        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
